// ===== sv/ple_pkg.sv =====
// Package for the positional list engine.
// Holds the request and status codes, controller states and the cell control bundle.
// No dependencies.
package ple_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W = 7;
    localparam int STATUS_W = 2;
    localparam int REQ_W = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_READ   = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_UNUSED = 2'd3
    } ple_req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } ple_status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_BUSY = 1'b1
    } ple_state_t;

    typedef struct packed {
        logic ins;
        logic del;
        logic capture;
    } ple_cell_ctl_t;

endpackage

// ===== sv/ple_cell.sv =====
// One list cell: holds one entry and shifts it toward either neighbor.
// It also captures its entry for the read tree when its index is addressed.
// Depends on ple_pkg.
module ple_cell
    import ple_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CMPW = 7
) (
    input  logic              aclk,
    input  ple_cell_ctl_t     ctl,
    input  logic [CMPW-1:0]   pos,
    input  logic [DATA_W-1:0] item,
    input  logic [DATA_W-1:0] left_in,
    input  logic [DATA_W-1:0] right_in,
    output logic [DATA_W-1:0] data_out,
    output logic [DATA_W-1:0] hit_out
);

    localparam logic [CMPW-1:0] IDX_V = CMPW'(IDX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic [DATA_W-1:0] hit_reg;
    logic              at_pos;
    logic              past_pos;

    assign at_pos = (IDX_V == pos);
    assign past_pos = (IDX_V > pos);

    always_comb begin
        data_next = data_reg;
        if (ctl.ins) begin
            if (past_pos) begin
                data_next = left_in;
            end else if (at_pos) begin
                data_next = item;
            end
        end else if (ctl.del) begin
            if (past_pos || at_pos) begin
                data_next = right_in;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        if (ctl.capture) begin
            hit_reg <= at_pos ? data_reg : '0;
        end
    end

    assign data_out = data_reg;
    assign hit_out = hit_reg;

endmodule

// ===== sv/ple_or_tree.sv =====
// Registered four-way OR tree that gathers the addressed cell's entry.
// Each tree level is one register stage.
// Depends on ple_pkg.
module ple_or_tree
    import ple_pkg::*;
#(
    parameter int N = 64,
    parameter int LVL = 3
) (
    input  logic              aclk,
    input  logic [DATA_W-1:0] leaf_in [N],
    output logic [DATA_W-1:0] root_out
);

    localparam int P = 1 << (2 * LVL);
    localparam int I = (P - 1) / 3;

    logic [DATA_W-1:0] node_reg  [I];
    logic [DATA_W-1:0] node_next [I];

    for (genvar j = 0; j < I; j++) begin : g_node
        logic [DATA_W-1:0] kid [4];
        for (genvar c = 0; c < 4; c++) begin : g_kid
            if (4 * j + c + 1 < I) begin : g_inner
                assign kid[c] = node_reg[4 * j + c + 1];
            end else if (4 * j + c + 1 - I < N) begin : g_leaf
                assign kid[c] = leaf_in[4 * j + c + 1 - I];
            end else begin : g_pad
                assign kid[c] = '0;
            end
        end
        assign node_next[j] = kid[0] | kid[1] | kid[2] | kid[3];
    end

    always_ff @(posedge aclk) begin
        node_reg <= node_next;
    end

    assign root_out = node_reg[0];

endmodule

// ===== sv/positional_list_engine_unit.sv =====
// Positional list engine: an ordered list of signed 32-bit entries in a row of shifting cells.
// Result path: the cell capture registers, the LVL register levels of the four-way read tree,
// LVL = ceil(log2(MAX_ENTRIES) / 2), then the output register, which stalls on m_tready low.
// A new request waits until the last result is loaded; insert and delete shift all cells at once.
// Reset: aresetn (synchronous, active low) empties the list and the output; cells are not cleared.
// Depends on ple_pkg, ple_cell and ple_or_tree.
module positional_list_engine_unit
    import ple_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // req_type[1:0], position[8:2], item_value[40:9], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // status[1:0], read_value[33:2], entry_total[40:34], zero pad
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam int LVL = ($clog2(MAX_ENTRIES) + 1) / 2;
    localparam int WW = $clog2(LVL + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(MAX_ENTRIES);

    ple_state_t        state_reg;
    ple_state_t        state_next;
    logic [WW-1:0]     wait_reg;
    logic [WW-1:0]     wait_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    ple_status_t       status_reg;
    ple_status_t       status_next;
    logic              rd_ok_reg;
    logic              rd_ok_next;
    logic              m_tvalid_reg;
    logic              m_tvalid_next;
    logic [47:0]       m_tdata_reg;
    logic [47:0]       m_tdata_next;

    ple_req_t          req;
    logic [CMPW-1:0]   pos;
    logic [CMPW-1:0]   cnt_ext;
    logic [DATA_W-1:0] item;
    logic              accept;
    logic              load_out;
    logic              ins_ok;
    logic              del_ok;
    ple_cell_ctl_t     ctl;

    logic [DATA_W-1:0] cell_data [MAX_ENTRIES];
    logic [DATA_W-1:0] cell_hit  [MAX_ENTRIES];
    logic [DATA_W-1:0] root;
    logic [DATA_W-1:0] rd_value;

    assign req = ple_req_t'(s_tdata[1:0]);
    assign pos = CMPW'(s_tdata[8:2]);
    assign item = s_tdata[40:9];
    assign cnt_ext = CMPW'(count_reg);
    assign accept = s_tvalid && s_tready;

    always_comb begin
        status_next = ST_OK;
        rd_ok_next = 1'b0;
        ins_ok = 1'b0;
        del_ok = 1'b0;
        count_next = count_reg;
        unique case (req)
            REQ_INSERT: begin
                if (pos > cnt_ext) begin
                    status_next = ST_BADPOS;
                end else if (count_reg == FULL_CNT) begin
                    status_next = ST_FULL;
                end else begin
                    ins_ok = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            REQ_READ: begin
                if (count_reg == '0) begin
                    status_next = ST_EMPTY;
                end else if (pos >= cnt_ext) begin
                    status_next = ST_BADPOS;
                end else begin
                    rd_ok_next = 1'b1;
                end
            end
            REQ_DELETE: begin
                if (count_reg == '0) begin
                    status_next = ST_EMPTY;
                end else if (pos >= cnt_ext) begin
                    status_next = ST_BADPOS;
                end else begin
                    del_ok = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            default: begin
                status_next = ST_BADPOS;
            end
        endcase
    end

    assign ctl.ins = accept && ins_ok;
    assign ctl.del = accept && del_ok;
    assign ctl.capture = accept;

    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
        logic [DATA_W-1:0] left_w;
        logic [DATA_W-1:0] right_w;
        if (i == 0) begin : g_first
            assign left_w = item;
        end else begin : g_left
            assign left_w = cell_data[i - 1];
        end
        if (i == MAX_ENTRIES - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_right
            assign right_w = cell_data[i + 1];
        end
        ple_cell #(
            .IDX  (i),
            .CMPW (CMPW)
        ) u_cell (
            .aclk     (aclk),
            .ctl      (ctl),
            .pos      (pos),
            .item     (item),
            .left_in  (left_w),
            .right_in (right_w),
            .data_out (cell_data[i]),
            .hit_out  (cell_hit[i])
        );
    end

    ple_or_tree #(
        .N   (MAX_ENTRIES),
        .LVL (LVL)
    ) u_tree (
        .aclk     (aclk),
        .leaf_in  (cell_hit),
        .root_out (root)
    );

    assign load_out = (state_reg == S_BUSY) && (wait_reg == '0) && (!m_tvalid_reg || m_tready);
    assign rd_value = rd_ok_reg ? root : '0;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_BUSY;
                end
            end
            S_BUSY: begin
                if (load_out) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready = (state_reg == S_IDLE);
        wait_next = wait_reg;
        if (accept) begin
            wait_next = WW'(LVL);
        end else if ((state_reg == S_BUSY) && (wait_reg != '0)) begin
            wait_next = wait_reg - 1'b1;
        end
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next = m_tdata_reg;
        if (load_out) begin
            m_tvalid_next = 1'b1;
            m_tdata_next = {7'b0, POS_W'(count_reg), rd_value, status_reg};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            wait_reg <= '0;
            count_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            wait_reg <= wait_next;
            m_tvalid_reg <= m_tvalid_next;
            if (accept) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        if (accept) begin
            status_reg <= status_next;
            rd_ok_reg <= rd_ok_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;

endmodule

// ===== tb/tb_positional_list_engine_unit.sv =====
// Self-checking testbench for positional_list_engine_unit: a clocked driver and monitor
// check every result transfer against an ordered-list predictor with shifting cells.
// Depends on ple_pkg and positional_list_engine_unit.
module tb_positional_list_engine_unit;
    import ple_pkg::*;

    localparam int DEPTH = 64;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 1230;
    localparam int CALM_ITEMS = 150;

    typedef struct {
        ple_req_t    kind;
        logic [6:0]  pos;
        logic [31:0] val;
        bit          drain;
        bit          calm;
    } list_req_t;

    typedef struct packed {
        ple_status_t status;
        logic [31:0] rd;
        logic [6:0]  total;
    } list_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;

    list_req_t    req_q[$];
    list_result_t due_results[$];
    logic [31:0]  cells[DEPTH];
    int           held;
    int           gen_held;
    int           fail_cnt;
    int           src_gap;
    int           snk_gap;
    int           stall_cnt;
    bit           in_fire;
    bit           calm_now;
    bit           mark_drain;
    bit           mark_calm;

    positional_list_engine_unit #(
        .MAX_ENTRIES(DEPTH)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    function automatic list_result_t list_apply(ple_req_t kind, logic [6:0] pos,
                                                logic [31:0] val);
        list_result_t r;
        r.status = ST_OK;
        r.rd = '0;
        case (kind)
            REQ_INSERT: begin
                if (int'(pos) > held) begin
                    r.status = ST_BADPOS;
                end else if (held >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = held; i > int'(pos); i--) cells[i] = cells[i-1];
                    cells[pos] = val;
                    held++;
                end
            end
            REQ_READ: begin
                if (held == 0) r.status = ST_EMPTY;
                else if (int'(pos) >= held) r.status = ST_BADPOS;
                else r.rd = cells[pos];
            end
            REQ_DELETE: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else if (int'(pos) >= held) begin
                    r.status = ST_BADPOS;
                end else begin
                    for (int i = int'(pos); i + 1 < held; i++) cells[i] = cells[i+1];
                    held--;
                end
            end
            default: r.status = ST_BADPOS;
        endcase
        r.total = 7'(held);
        return r;
    endfunction

    task automatic push_req(ple_req_t kind, int pos, logic [31:0] val);
        list_req_t q;
        q.kind = kind;
        q.pos = 7'(pos);
        q.val = val;
        q.drain = mark_drain;
        q.calm = mark_calm;
        mark_drain = 1'b0;
        req_q.push_back(q);
        if (kind == REQ_INSERT && pos <= gen_held && gen_held < DEPTH) gen_held++;
        if (kind == REQ_DELETE && pos < gen_held) gen_held--;
    endtask

    // Stimulus generation runs ahead of time; gen_held tracks the entry count it expects.
    initial begin : stim
        int          bias;
        int          pick;
        int          pos;
        ple_req_t    kind;
        logic [31:0] val;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        gen_held = 0;
        mark_drain = 1'b0;
        mark_calm = 1'b0;

        push_req(REQ_READ, 0, 32'h0);
        push_req(REQ_DELETE, 0, 32'h0);
        push_req(REQ_INSERT, 1, 32'h1234_5678);
        push_req(REQ_UNUSED, 0, 32'hFFFF_FFFF);
        push_req(REQ_INSERT, 0, 32'h7FFF_FFFF);
        push_req(REQ_INSERT, 1, 32'h8000_0000);
        push_req(REQ_INSERT, 0, 32'hFFFF_FFFF);
        push_req(REQ_INSERT, 1, 32'h0000_0000);
        for (int i = 0; i < 4; i++) push_req(REQ_READ, i, 32'h0);
        push_req(REQ_READ, 4, 32'h0);
        push_req(REQ_READ, 127, 32'h0);
        push_req(REQ_DELETE, 127, 32'h0);
        push_req(REQ_INSERT, 127, 32'hA5A5_A5A5);
        push_req(REQ_INSERT, 4, 32'h5A5A_5A5A);
        push_req(REQ_DELETE, 1, 32'h0);
        push_req(REQ_DELETE, 0, 32'h0);
        push_req(REQ_DELETE, 2, 32'h0);
        push_req(REQ_READ, 0, 32'h0);
        push_req(REQ_DELETE, 1, 32'h0);
        push_req(REQ_DELETE, 0, 32'h0);
        push_req(REQ_READ, 0, 32'h0);

        // Phases cycle through filling, balanced, draining and balanced mixes so that both
        // the full and the empty list are reached many times.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            case ((n / 150) % 4)
                0: bias = 90;
                2: bias = 10;
                default: bias = 50;
            endcase
            mark_drain = (n % 300 == 0);
            mark_calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
            pick = $urandom_range(0, 99);
            if (pick < 2) kind = REQ_UNUSED;
            else if (pick < 22) kind = REQ_READ;
            else if ($urandom_range(0, 99) < bias) kind = REQ_INSERT;
            else kind = REQ_DELETE;
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                pos = $urandom_range(0, 127);
            end else if (kind == REQ_INSERT) begin
                pos = (pick < 24) ? gen_held : $urandom_range(0, gen_held);
            end else if (gen_held == 0) begin
                pos = 0;
            end else begin
                pos = (pick < 24) ? gen_held - 1 : $urandom_range(0, gen_held - 1);
            end
            pick = $urandom_range(0, 9);
            if (pick == 0) val = 32'h8000_0000;
            else if (pick == 1) val = 32'h7FFF_FFFF;
            else val = $urandom;
            push_req(kind, pos, val);
        end

        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        while (req_q.size() != 0 || s_tvalid || due_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (m_tvalid) begin
            $error("result transfer pending after the last expected result");
            fail_cnt++;
        end
        if (fail_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    always @(negedge aclk) begin : drive_req
        list_req_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_fire) begin
            if (src_gap > 0) begin
                src_gap--;
                s_tvalid <= 1'b0;
            end else if (!calm_now && $urandom_range(0, 5) == 0) begin
                src_gap = $urandom_range(0, 6);
                s_tvalid <= 1'b0;
            end else if (req_q.size() == 0 || (req_q[0].drain && due_results.size() != 0)) begin
                s_tvalid <= 1'b0;
            end else begin
                nxt = req_q.pop_front();
                calm_now = nxt.calm;
                s_tdata <= {7'b0, nxt.val, nxt.pos, nxt.kind};
                s_tvalid <= 1'b1;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (snk_gap > 0) begin
            snk_gap--;
            m_tready <= 1'b0;
        end else if (!calm_now && $urandom_range(0, 7) == 0) begin
            snk_gap = $urandom_range(0, 6);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : observe
        list_result_t want;
        if (!aresetn) begin
            in_fire <= 1'b0;
            held = 0;
        end else begin
            in_fire <= s_tvalid && s_tready;
            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    $error("result transfer with no request outstanding: %h", m_tdata);
                    fail_cnt++;
                end else begin
                    want = due_results.pop_front();
                    if (m_tdata[1:0] !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tdata[1:0]);
                        fail_cnt++;
                    end
                    if (m_tdata[33:2] !== want.rd) begin
                        $error("read_value: expected %0d, got %0d",
                               $signed(want.rd), $signed(m_tdata[33:2]));
                        fail_cnt++;
                    end
                    if (m_tdata[40:34] !== want.total) begin
                        $error("entry_total: expected %0d, got %0d", want.total,
                               m_tdata[40:34]);
                        fail_cnt++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                due_results.push_back(list_apply(ple_req_t'(s_tdata[1:0]), s_tdata[8:2],
                                                 s_tdata[40:9]));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    initial begin
        fail_cnt = 0;
        src_gap = 0;
        snk_gap = 0;
        stall_cnt = 0;
        in_fire = 1'b0;
        calm_now = 1'b0;
        held = 0;
    end

endmodule

// ===== filelist.f =====
sv/ple_pkg.sv
sv/ple_cell.sv
sv/ple_or_tree.sv
sv/positional_list_engine_unit.sv
tb/tb_positional_list_engine_unit.sv
